@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define STDM_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stdm assertion failed");

// Next-cycle implication, disabled while reset is applied.
`define STDM_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stdm assertion failed");

`endif

@@ rtl/stdm_pkg.sv @@
// ----------------------------------------------------------------------------
// stdm_pkg
// Types, widths and helpers shared by the statistical TDM frame builder.
// ----------------------------------------------------------------------------
package stdm_pkg;

	localparam int MASK_W  = 8;
	localparam int SRC_W   = 3;
	localparam int LABEL_W = 16;
	localparam int CFG_W   = 5;

	// One frame time as handed from the front part to the back part.
	typedef struct packed {
		logic [MASK_W-1:0]              pend;
		logic [MASK_W-1:0][LABEL_W-1:0] label;
	} stdm_frame_t;

	// One backlog entry.
	typedef struct packed {
		logic [SRC_W-1:0]   src;
		logic [LABEL_W-1:0] label;
	} stdm_entry_t;

	// Contents of one subframe.
	typedef struct packed {
		logic               used;
		logic [SRC_W-1:0]   src;
		logic [LABEL_W-1:0] label;
	} stdm_unit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLOT_RD,
		ST_SLOT,
		ST_APPEND,
		ST_LAST
	} stdm_state_t;

	// Index of the lowest set bit; zero when no bit is set.
	function automatic logic [SRC_W-1:0] lowest_set(input logic [MASK_W-1:0] m);
		logic [SRC_W-1:0] r;
		r = '0;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = SRC_W'(i);
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/stdm_front.sv @@
// ----------------------------------------------------------------------------
// stdm_front
// Accepts one frame time per request, bumps the arrival counters of the
// sources that deliver a unit and passes the labelled pending set onward.
// ----------------------------------------------------------------------------
module stdm_front #(
	parameter int NUM_SOURCES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [stdm_pkg::MASK_W-1:0] ready_mask,
	output logic                        push_valid,
	input  logic                        push_ready,
	output stdm_pkg::stdm_frame_t       push_data
);

	logic [stdm_pkg::MASK_W-1:0][stdm_pkg::LABEL_W-1:0] cnt_q;
	logic [stdm_pkg::MASK_W-1:0]                        live_c;
	logic                                               accept_c;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept_c   = in_valid && push_ready;

	// Mask bits for sources the block does not have never count.
	always_comb begin
		for (int i = 0; i < stdm_pkg::MASK_W; i++) begin
			live_c[i]             = ready_mask[i] && (i < NUM_SOURCES);
			push_data.label[i]    = cnt_q[i] + 1'b1;
		end
		push_data.pend = live_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept_c) begin
			for (int i = 0; i < stdm_pkg::MASK_W; i++) begin
				if (live_c[i]) begin
					cnt_q[i] <= cnt_q[i] + 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/stdm_fifo.sv @@
// ----------------------------------------------------------------------------
// stdm_fifo
// Two-entry queue of frame times between the front and the back part.
// ----------------------------------------------------------------------------
module stdm_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  stdm_pkg::stdm_frame_t push_data,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output stdm_pkg::stdm_frame_t pop_data
);

	stdm_pkg::stdm_frame_t mem_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;
	logic                  push_c;
	logic                  pop_c;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push_c     = push_valid && push_ready;
	assign pop_c      = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_c) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_c) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_c) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push_c, pop_c})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/stdm_back.sv @@
// ----------------------------------------------------------------------------
// stdm_back
// Builds the subframes of one frame time: serves the backlog first, then the
// lowest pending source, then appends leftovers to the backlog memory.
// ----------------------------------------------------------------------------
module stdm_back #(
	parameter int BACKLOG_DEPTH = 64,
	parameter int MAX_SUBFRAMES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [stdm_pkg::CFG_W-1:0] cfg_subframes,
	input  logic                       pop_valid,
	output logic                       pop_ready,
	input  stdm_pkg::stdm_frame_t      pop_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output stdm_pkg::stdm_unit_t       out_unit,
	output logic                       out_last,
	output logic                       out_drop
);

	localparam int PTR_W = $clog2(BACKLOG_DEPTH);
	localparam int CNT_W = $clog2(BACKLOG_DEPTH + 1);

	stdm_pkg::stdm_entry_t mem [BACKLOG_DEPTH];
	stdm_pkg::stdm_entry_t rd_data_q;

	stdm_pkg::stdm_state_t state_q;
	stdm_pkg::stdm_state_t state_d;

	logic [PTR_W-1:0]                                   head_q;
	logic [CNT_W-1:0]                                   count_q;
	logic [stdm_pkg::MASK_W-1:0]                        pend_q;
	logic [stdm_pkg::MASK_W-1:0][stdm_pkg::LABEL_W-1:0] label_q;
	logic [stdm_pkg::CFG_W-1:0]                         slot_q;
	stdm_pkg::stdm_unit_t                               hold_q;
	logic                                               drop_q;

	logic                 out_valid_q;
	stdm_pkg::stdm_unit_t out_unit_q;
	logic                 out_last_q;
	logic                 out_drop_q;

	logic [stdm_pkg::CFG_W-1:0] n_c;
	logic                       out_free_c;
	logic                       have_bl_c;
	logic                       pend_any_c;
	logic                       full_c;
	logic [stdm_pkg::SRC_W-1:0] pick_c;
	logic                       is_last_c;
	logic [PTR_W:0]             tail_sum_c;
	logic [PTR_W-1:0]           tail_c;
	logic [PTR_W-1:0]           head_inc_c;
	stdm_pkg::stdm_unit_t       slot_unit_c;

	// Control decoded from the state.
	logic take_c;
	logic load_slot_c;
	logic load_last_c;
	logic append_c;
	logic frame_pop_c;

	// Subframe count: zero counts as one, large values saturate.
	always_comb begin
		n_c = cfg_subframes;
		if (cfg_subframes == '0) begin
			n_c = stdm_pkg::CFG_W'(1);
		end else if (32'(cfg_subframes) > MAX_SUBFRAMES) begin
			n_c = stdm_pkg::CFG_W'(MAX_SUBFRAMES);
		end
	end

	assign out_free_c = !out_valid_q || out_ready;
	assign have_bl_c  = (count_q != '0);
	assign pend_any_c = |pend_q;
	assign full_c     = (count_q == CNT_W'(BACKLOG_DEPTH));
	assign pick_c     = stdm_pkg::lowest_set(pend_q);
	assign is_last_c  = (slot_q == n_c - 1'b1);

	assign tail_sum_c = (PTR_W+1)'(head_q) + (PTR_W+1)'(count_q);
	assign tail_c     = (tail_sum_c >= (PTR_W+1)'(BACKLOG_DEPTH))
		? PTR_W'(tail_sum_c - (PTR_W+1)'(BACKLOG_DEPTH)) : tail_sum_c[PTR_W-1:0];
	assign head_inc_c = (head_q == PTR_W'(BACKLOG_DEPTH - 1)) ? '0 : head_q + 1'b1;

	always_comb begin
		slot_unit_c = '0;
		if (have_bl_c) begin
			slot_unit_c.used  = 1'b1;
			slot_unit_c.src   = rd_data_q.src;
			slot_unit_c.label = rd_data_q.label;
		end else if (pend_any_c) begin
			slot_unit_c.used  = 1'b1;
			slot_unit_c.src   = pick_c;
			slot_unit_c.label = label_q[pick_c];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stdm_pkg::ST_IDLE: begin
				if (pop_valid) begin
					state_d = stdm_pkg::ST_SLOT_RD;
				end
			end
			stdm_pkg::ST_SLOT_RD: state_d = stdm_pkg::ST_SLOT;
			stdm_pkg::ST_SLOT: begin
				if (is_last_c) begin
					state_d = stdm_pkg::ST_APPEND;
				end else if (out_free_c) begin
					state_d = stdm_pkg::ST_SLOT_RD;
				end
			end
			stdm_pkg::ST_APPEND: begin
				if (!pend_any_c) begin
					state_d = stdm_pkg::ST_LAST;
				end
			end
			stdm_pkg::ST_LAST: begin
				if (out_free_c) begin
					state_d = stdm_pkg::ST_IDLE;
				end
			end
			default: state_d = stdm_pkg::ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		pop_ready   = 1'b0;
		frame_pop_c = 1'b0;
		take_c      = 1'b0;
		load_slot_c = 1'b0;
		load_last_c = 1'b0;
		append_c    = 1'b0;
		unique case (state_q)
			stdm_pkg::ST_IDLE: begin
				pop_ready   = 1'b1;
				frame_pop_c = pop_valid;
			end
			stdm_pkg::ST_SLOT_RD: begin
			end
			stdm_pkg::ST_SLOT: begin
				take_c      = is_last_c || out_free_c;
				load_slot_c = !is_last_c && out_free_c;
			end
			stdm_pkg::ST_APPEND: append_c = pend_any_c;
			stdm_pkg::ST_LAST:   load_last_c = out_free_c;
			default: begin
			end
		endcase
	end

	// Backlog memory: one write port at the tail, registered read at the head.
	always_ff @(posedge clk) begin
		if (append_c && !full_c) begin
			mem[tail_c] <= '{src: pick_c, label: label_q[pick_c]};
		end
		rd_data_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stdm_pkg::ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			pend_q      <= '0;
			slot_q      <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (frame_pop_c) begin
				pend_q <= pop_data.pend;
				slot_q <= '0;
				drop_q <= 1'b0;
			end
			if (take_c) begin
				slot_q <= slot_q + 1'b1;
				if (have_bl_c) begin
					head_q  <= head_inc_c;
					count_q <= count_q - 1'b1;
				end else if (pend_any_c) begin
					pend_q[pick_c] <= 1'b0;
				end
			end
			if (append_c) begin
				pend_q[pick_c] <= 1'b0;
				if (full_c) begin
					drop_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			if (load_slot_c || load_last_c) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (frame_pop_c) begin
			label_q <= pop_data.label;
		end
		if (take_c && is_last_c) begin
			hold_q <= slot_unit_c;
		end
		if (load_slot_c) begin
			out_unit_q <= slot_unit_c;
			out_last_q <= 1'b0;
			out_drop_q <= 1'b0;
		end else if (load_last_c) begin
			out_unit_q <= hold_q;
			out_last_q <= 1'b1;
			out_drop_q <= drop_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_unit  = out_unit_q;
	assign out_last  = out_last_q;
	assign out_drop  = out_drop_q;

endmodule

@@ rtl/statistical_tdm_frame_builder_unit.sv @@
// ----------------------------------------------------------------------------
// statistical_tdm_frame_builder_unit
// Statistical TDM frame builder: one request per frame time in, one result
// per subframe out, with a backlog of leftover units carried between frames.
// ----------------------------------------------------------------------------
// A frame time occupies the subframe sequencer while its n subframes are built
// and its leftover units are appended to the backlog. Each subframe passes
// through a read state and a slot state because the backlog head is read
// from a memory with a registered read port, and each leftover unit is written
// through the single write port of that memory. A two-entry queue lets new
// frame times be accepted and labelled while an earlier one is still being
// built, and an output register holds a finished result until it is taken.
// The backlog memory needs no clearing after reset: only entries that have
// been written are ever used.
module statistical_tdm_frame_builder_unit #(
	parameter int NUM_SOURCES   = 8,
	parameter int BACKLOG_DEPTH = 64,
	parameter int MAX_SUBFRAMES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [stdm_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [stdm_pkg::MASK_W-1:0]  ready_mask,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         slot_used,
	output logic [stdm_pkg::SRC_W-1:0]   source_index,
	output logic [stdm_pkg::LABEL_W-1:0] unit_label,
	output logic                         last_in_frame,
	output logic                         backlog_dropped
);

	logic [stdm_pkg::CFG_W-1:0] cfg_q;
	logic                       push_valid;
	logic                       push_ready;
	stdm_pkg::stdm_frame_t      push_data;
	logic                       pop_valid;
	logic                       pop_ready;
	stdm_pkg::stdm_frame_t      pop_data;
	stdm_pkg::stdm_unit_t       out_unit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= stdm_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	stdm_front #(
		.NUM_SOURCES (NUM_SOURCES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ready_mask (ready_mask),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	stdm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	stdm_back #(
		.BACKLOG_DEPTH (BACKLOG_DEPTH),
		.MAX_SUBFRAMES (MAX_SUBFRAMES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_subframes (cfg_q),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_data      (pop_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_unit      (out_unit),
		.out_last      (last_in_frame),
		.out_drop      (backlog_dropped)
	);

	assign slot_used    = out_unit.used;
	assign source_index = out_unit.src;
	assign unit_label   = out_unit.label;

endmodule

@@ rtl/stdm_checker.sv @@
// ----------------------------------------------------------------------------
// stdm_checker
// Port-level checks on the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stdm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         slot_used,
	input logic [stdm_pkg::SRC_W-1:0]   source_index,
	input logic [stdm_pkg::LABEL_W-1:0] unit_label,
	input logic                         last_in_frame,
	input logic                         backlog_dropped
);

	// The drop flag belongs to the closing subframe of a frame only.
	`STDM_ASSERT_IMP(a_drop_on_last, out_valid && backlog_dropped, last_in_frame)

	// An empty subframe carries neither a source nor a label.
	`STDM_ASSERT_IMP(a_empty_is_zero, out_valid && !slot_used, (source_index == '0) && (unit_label == '0))

	// A result that is not taken stays on the port unchanged.
	`STDM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(slot_used) && $stable(source_index) && $stable(unit_label) && $stable(last_in_frame) && $stable(backlog_dropped))

endmodule

bind statistical_tdm_frame_builder_unit stdm_checker u_stdm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.slot_used       (slot_used),
	.source_index    (source_index),
	.unit_label      (unit_label),
	.last_in_frame   (last_in_frame),
	.backlog_dropped (backlog_dropped)
);
